// ----- rtl/i2cm_pkg.sv -----
// Shared types and constants of the I2C master byte engine.
package i2cm_pkg;

	typedef enum logic [2:0] {
		OP_TICK  = 3'd0,
		OP_START = 3'd1,
		OP_WRITE = 3'd2,
		OP_READ  = 3'd3,
		OP_STOP  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		CMD_IDLE  = 3'd0,
		CMD_START = 3'd1,
		CMD_WRITE = 3'd2,
		CMD_READ  = 3'd3,
		CMD_STOP  = 3'd4
	} cmd_t;

	localparam logic [1:0]  PH_FIRST  = 2'd0;
	localparam logic [1:0]  PH_SECOND = 2'd1;
	localparam logic [1:0]  PH_SETUP  = 2'd2;
	localparam logic [1:0]  PH_HIGH   = 2'd3;
	localparam logic [3:0]  ACK_BIT   = 4'd8;
	localparam logic [15:0] PHASE_TICKS_RESET = 16'd200;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] address;
		logic       read_mode;
		logic [7:0] data_byte;
		logic       ack_after;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic       scl_release;
		logic       sda_release;
		logic       busy_res;
		logic       done_res;
		logic       ack_seen;
		logic [7:0] read_value;
		logic       error;
		logic       rejected;
	} result_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [1:0]  phase;
		logic [3:0]  bits;
		logic [15:0] ticks;
		logic [7:0]  shift;
		logic        scl;
		logic        sda;
		logic        nack;
		logic        ack_choice;
		logic        ack_flag;
		logic [7:0]  rdval;
	} eng_state_t;

	localparam eng_state_t ENG_RESET = '{
		cmd: CMD_IDLE, phase: PH_FIRST, bits: 4'd0, ticks: 16'd0, shift: 8'd0,
		scl: 1'b1, sda: 1'b1, nack: 1'b0, ack_choice: 1'b0, ack_flag: 1'b0,
		rdval: 8'd0
	};

endpackage

// ----- rtl/i2c_master_byte_engine.sv -----
// I2C master byte engine (7-bit addressing): top level with input and result registers.
// Each input word is a tick or a command (start plus address, write byte, read byte,
// stop) and yields exactly one result word; a new word is accepted every cycle
// as long as the result side keeps up. An accepted word waits in the input
// register, and the result register loads its result once that register is free.
// Ticks advance the bus,
// one phase lasting phase_ticks ticks (0 acts as 1, reset 200). A NACK on an
// address or write byte sets a sticky error: later start/write/read commands
// complete at once with error set, while stop always runs and clears it.
// Commands that arrive while busy are reported as rejected. Write cfg_wdata via
// cfg_we only while no word is in flight; a write during a command applies from
// the next tick on.
module i2c_master_byte_engine import i2cm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic [7:0]  address,
	input  logic        read_mode,
	input  logic [7:0]  data_byte,
	input  logic        ack_after,
	input  logic        sda_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        scl_release,
	output logic        sda_release,
	output logic        busy_res,
	output logic        done_res,
	output logic        ack_seen,
	output logic [7:0]  read_value,
	output logic        error,
	output logic        rejected
);

	logic [15:0] phase_ticks_q;
	logic        valid_s1;
	item_t       item_s1;
	logic        step;
	logic        out_free;
	result_t     res_core;
	result_t     res_q;

	assign step     = valid_s1 && out_free;
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_TICKS_RESET;
		end else if (cfg_we) begin
			phase_ticks_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= '{operation: operation, address: address, read_mode: read_mode,
				data_byte: data_byte, ack_after: ack_after, sda_in: sda_in};
		end
	end

	i2cm_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.item        (item_s1),
		.phase_ticks (phase_ticks_q),
		.res         (res_core)
	);

	i2cm_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step),
		.res_in    (res_core),
		.out_ready (out_ready),
		.free      (out_free),
		.out_valid (out_valid),
		.res_out   (res_q)
	);

	assign scl_release = res_q.scl_release;
	assign sda_release = res_q.sda_release;
	assign busy_res    = res_q.busy_res;
	assign done_res    = res_q.done_res;
	assign ack_seen    = res_q.ack_seen;
	assign read_value  = res_q.read_value;
	assign error       = res_q.error;
	assign rejected    = res_q.rejected;

endmodule

// ----- rtl/i2cm_core.sv -----
// Bus sequencer: engine state registers and the per-word next-state logic.
module i2cm_core import i2cm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  item_t       item,
	input  logic [15:0] phase_ticks,
	output result_t     res
);

	eng_state_t cur_q;
	eng_state_t nxt;

	// Drive SCL low and put the next bit (or ack) on SDA.
	function automatic eng_state_t begin_bit(eng_state_t s);
		eng_state_t r;
		r = s;
		r.scl = 1'b0;
		if (s.cmd == CMD_READ) begin
			r.sda = (s.bits >= ACK_BIT) ? ~s.ack_choice : 1'b1;
		end else begin
			r.sda = (s.bits >= ACK_BIT) ? 1'b1 : s.shift[7];
		end
		r.phase = PH_SETUP;
		return r;
	endfunction

	always_comb begin
		logic        done;
		logic        rej;
		logic        cleared;
		logic        fin;
		logic [15:0] limit;
		logic [7:0]  addr;
		nxt     = cur_q;
		done    = 1'b0;
		rej     = 1'b0;
		cleared = 1'b0;
		fin     = 1'b0;
		limit   = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
		addr    = item.address[7] ? {1'b0, item.address[7:1]} : item.address;
		unique case (op_t'(item.operation))
			OP_START, OP_WRITE, OP_READ, OP_STOP: begin
				if (cur_q.cmd != CMD_IDLE) begin
					rej = 1'b1;
				end else if (op_t'(item.operation) != OP_STOP && cur_q.nack) begin
					done = 1'b1;
				end else begin
					nxt.cmd   = cmd_t'(item.operation);
					nxt.ticks = 16'd0;
					nxt.bits  = 4'd0;
					unique case (op_t'(item.operation))
						OP_START: begin
							nxt.shift = {addr[6:0], item.read_mode};
							nxt.scl   = 1'b1;
							nxt.sda   = 1'b1;
							nxt.phase = PH_FIRST;
						end
						OP_WRITE: begin
							nxt.shift = item.data_byte;
							nxt = begin_bit(nxt);
						end
						OP_READ: begin
							nxt.shift      = 8'd0;
							nxt.ack_choice = item.ack_after;
							nxt = begin_bit(nxt);
						end
						default: begin
							nxt.sda   = 1'b0;
							nxt.phase = PH_FIRST;
						end
					endcase
				end
			end
			OP_TICK: begin
				if (cur_q.cmd != CMD_IDLE) begin
					nxt.ticks = cur_q.ticks + 16'd1;
					if (nxt.ticks >= limit) begin
						nxt.ticks = 16'd0;
						if (cur_q.cmd == CMD_STOP) begin
							unique case (cur_q.phase)
								PH_FIRST: begin
									nxt.scl   = 1'b1;
									nxt.phase = PH_SECOND;
								end
								PH_SECOND: begin
									nxt.sda   = 1'b1;
									nxt.phase = PH_SETUP;
								end
								default: fin = 1'b1;
							endcase
						end else begin
							unique case (cur_q.phase)
								PH_FIRST: begin
									nxt.sda   = 1'b0;
									nxt.phase = PH_SECOND;
								end
								PH_SECOND: begin
									nxt.bits = 4'd0;
									nxt = begin_bit(nxt);
								end
								PH_SETUP: begin
									nxt.scl   = 1'b1;
									nxt.phase = PH_HIGH;
								end
								default: begin
									nxt.scl = 1'b0;
									if (cur_q.bits < ACK_BIT) begin
										nxt.shift = (cur_q.cmd == CMD_READ) ?
											{cur_q.shift[6:0], item.sda_in} :
											{cur_q.shift[6:0], 1'b0};
										nxt.bits = cur_q.bits + 4'd1;
										nxt = begin_bit(nxt);
									end else begin
										fin = 1'b1;
										if (cur_q.cmd == CMD_READ) begin
											nxt.rdval = cur_q.shift;
										end else begin
											nxt.ack_flag = ~item.sda_in;
											if (item.sda_in) begin
												nxt.nack = 1'b1;
											end
										end
									end
								end
							endcase
						end
						if (fin) begin
							done      = 1'b1;
							cleared   = (cur_q.cmd == CMD_STOP);
							nxt.cmd   = CMD_IDLE;
							nxt.phase = PH_FIRST;
							nxt.bits  = 4'd0;
						end
					end
				end
			end
			default: ;
		endcase

		// error shows the flag before a completed stop clears it
		res.scl_release = nxt.scl;
		res.sda_release = nxt.sda;
		res.busy_res    = (nxt.cmd != CMD_IDLE);
		res.done_res    = done;
		res.ack_seen    = nxt.ack_flag;
		res.read_value  = nxt.rdval;
		res.error       = nxt.nack;
		res.rejected    = rej;
		if (cleared) begin
			nxt.nack = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= ENG_RESET;
		end else if (step) begin
			cur_q <= nxt;
		end
	end

endmodule

// ----- rtl/i2cm_out_reg.sv -----
// Result register of the output channel.
module i2cm_out_reg import i2cm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res_in,
	input  logic    out_ready,
	output logic    free,
	output logic    out_valid,
	output result_t res_out
);

	logic    valid_q;
	result_t res_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign res_out   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

// ----- rtl/i2cm_checker.sv -----
// Port-level checker for the I2C master byte engine, bound to the top level.
module i2cm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        scl_release,
	input logic        busy_res,
	input logic        done_res,
	input logic [7:0]  read_value,
	input logic        rejected
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_value) &&
			$stable(done_res) && $stable(busy_res) && $stable(scl_release))
		else $error("result word changed while stalled");

	// a finished command leaves the engine idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done reported while still busy");

	// only a busy engine rejects
	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> busy_res)
		else $error("reject while idle");

	a_rej_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(rejected && done_res))
		else $error("word both rejected and done");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (.*);
